// ----- hw/rtl/sm4_gcm_engine_top_defines.svh -----
`ifndef SM4_GCM_ENGINE_TOP_DEFINES_SVH
`define SM4_GCM_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SGCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define SGCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sgcm_pkg.sv -----
`default_nettype none
package sgcm_pkg;

    typedef enum logic [1:0] {
        OP_AAD  = 2'd0,
        OP_TEXT = 2'd1,
        OP_FIN  = 2'd2,
        OP_SKIP = 2'd3
    } t_op;

    localparam logic [2:0] REG_KEY_H = 3'd0;
    localparam logic [2:0] REG_KEY_L = 3'd1;
    localparam logic [2:0] REG_IV_H  = 3'd2;
    localparam logic [2:0] REG_IV_L  = 3'd3;
    localparam logic [2:0] REG_DEC   = 3'd4;

    localparam logic [127:0] FK = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;
    localparam logic [127:0] GF_R = {8'hE1, 120'd0};

    localparam logic [2047:0] SBOX_BITS = {
        128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    typedef struct packed {
        logic         key_start;
        logic         blk_start;
        logic [127:0] blk;
    } t_cip_req;

    typedef struct packed {
        logic         done;
        logic [127:0] res;
    } t_cip_sts;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [10:0] idx;
        idx = 11'd2047 - {a, 3'b000};
        return SBOX_BITS[idx -: 8];
    endfunction

    function automatic logic [31:0] tau(input logic [31:0] x);
        return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // x is {x0, x1, x2, x3}, x0 on top
    function automatic logic [127:0] sm4_round(input logic [127:0] x, input logic [31:0] rk);
        logic [31:0] b;
        logic [31:0] nx;
        b  = tau(x[95:64] ^ x[63:32] ^ x[31:0] ^ rk);
        nx = x[127:96] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
        return {x[95:0], nx};
    endfunction

    function automatic logic [31:0] sm4_ck(input logic [4:0] i);
        logic [31:0] ck;
        logic [9:0]  v;
        ck = '0;
        for (int j = 0; j < 4; j++) begin
            v = ({3'b000, i, 2'b00} + 10'(j)) * 10'd7;
            ck[31 - 8*j -: 8] = v[7:0];
        end
        return ck;
    endfunction

    function automatic logic [31:0] key_step(input logic [127:0] k, input logic [4:0] i);
        logic [31:0] b;
        b = tau(k[95:64] ^ k[63:32] ^ k[31:0] ^ sm4_ck(i));
        return k[127:96] ^ b ^ rol(b, 13) ^ rol(b, 23);
    endfunction

    function automatic logic [127:0] lead_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int b = 0; b < 16; b++) begin
            m[127 - 8*b -: 8] = (5'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // four GF(2^128) multiply steps, x bits taken most significant first
    function automatic logic [255:0] ghash_step4(input logic [127:0] z, input logic [127:0] v,
                                                 input logic [3:0] xb);
        logic [127:0] zz;
        logic [127:0] vv;
        logic         lsb;
        zz = z;
        vv = v;
        for (int i = 3; i >= 0; i--) begin
            if (xb[i]) begin
                zz = zz ^ vv;
            end
            lsb = vv[0];
            vv  = vv >> 1;
            if (lsb) begin
                vv = vv ^ GF_R;
            end
        end
        return {zz, vv};
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sm4_gcm_engine_top.sv -----
// Channel | Direction | Handshake                  | Word
// in      | input     | i_in_valid / o_in_stall    | operation, data halves, valid bytes
// out     | output    | o_out_valid / i_out_stall  | result halves, is_tag, tag_ok
// config  | input     | APB psel/penable/pwrite    | five registers at 8*i, 64-bit data
// One word is taken at a time; the first word of a message first expands the round keys
// and then encrypts the zero block. A text word with data runs the cipher rounds and then
// GHASH, 4 bits a cycle; a finish word runs GHASH, then the cipher; a non-empty AAD word GHASH.
// The round-key memory feeds one SM4 round per cycle. Reset is synchronous, active low.
// A result stalled on the output is held while the next input word is taken.
`default_nettype none
module sm4_gcm_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_data_high,
    input  wire logic [63:0] i_data_low,
    input  wire logic [4:0]  i_valid_bytes,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_out_high,
    output logic [63:0]      o_out_low,
    output logic             o_is_tag,
    output logic             o_tag_ok,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import sgcm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_KEYW = 8'b0000_0010,
        S_HW   = 8'b0000_0100,
        S_DISP = 8'b0000_1000,
        S_CW   = 8'b0001_0000,
        S_GW   = 8'b0010_0000,
        S_JW   = 8'b0100_0000,
        S_PUSH = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        G_IDLE = 3'b001,
        G_PUSH = 3'b010,
        G_J0   = 3'b100
    } t_after;

    logic [63:0]  r_key_h, r_key_l, r_iv_h;
    logic [31:0]  r_iv_l;
    logic         r_dec;

    t_state       r_state;
    t_after       r_after;
    t_op          r_op;
    logic [127:0] r_data;
    logic [4:0]   r_n;
    logic         r_in_msg;
    logic [127:0] r_hkey;
    logic [127:0] r_acc;
    logic [31:0]  r_ctr;
    logic [60:0]  r_aad_cnt, r_txt_cnt;
    logic [127:0] r_res;
    logic         r_res_tag, r_res_ok;

    logic         r_ov;
    logic [127:0] r_out;
    logic         r_out_tag, r_out_ok;

    t_cip_req     cip_req;
    t_cip_sts     cip_sts;
    logic         g_start;
    logic [127:0] g_x;
    logic         g_done;
    logic [127:0] g_z;

    logic         cfg_wr;
    logic         in_acc;
    logic [4:0]   n_clamp;
    logic [127:0] mask;
    logic [127:0] ctext;
    logic [127:0] tag;
    logic [127:0] lens;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign n_clamp = (i_valid_bytes > 5'd16) ? 5'd16 : i_valid_bytes;
    assign mask    = lead_mask(r_n);
    assign ctext   = (r_data ^ cip_sts.res) & mask;
    assign tag     = cip_sts.res ^ r_acc;
    assign lens    = {r_aad_cnt, 3'b000, r_txt_cnt, 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_h <= '0;
            r_key_l <= '0;
            r_iv_h  <= '0;
            r_iv_l  <= '0;
            r_dec   <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_KEY_H: r_key_h <= pwdata;
                REG_KEY_L: r_key_l <= pwdata;
                REG_IV_H:  r_iv_h  <= pwdata;
                REG_IV_L:  r_iv_l  <= pwdata[31:0];
                REG_DEC:   r_dec   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_KEY_H: prdata = r_key_h;
            REG_KEY_L: prdata = r_key_l;
            REG_IV_H:  prdata = r_iv_h;
            REG_IV_L:  prdata = {32'd0, r_iv_l};
            REG_DEC:   prdata = {63'd0, r_dec};
            default:   prdata = '0;
        endcase
    end

    // launches into the cipher and the hash unit
    always_comb begin
        cip_req.key_start = 1'b0;
        cip_req.blk_start = 1'b0;
        cip_req.blk       = '0;
        g_start           = 1'b0;
        g_x               = '0;
        case (r_state)
            S_KEYW: begin
                cip_req.blk_start = cip_sts.done;
            end
            S_DISP: begin
                if (r_op == OP_AAD && r_n != 5'd0) begin
                    g_start = 1'b1;
                    g_x     = r_acc ^ (r_data & mask);
                end else if (r_op == OP_TEXT && r_n != 5'd0) begin
                    cip_req.blk_start = 1'b1;
                    cip_req.blk       = {r_iv_h, r_iv_l, r_ctr};
                end else if (r_op == OP_FIN) begin
                    g_start = 1'b1;
                    g_x     = r_acc ^ lens;
                end
            end
            S_CW: begin
                g_start = cip_sts.done;
                g_x     = r_acc ^ (r_dec ? (r_data & mask) : ctext);
            end
            S_GW: begin
                cip_req.blk_start = g_done && (r_after == G_J0);
                cip_req.blk       = {r_iv_h, r_iv_l, 32'd1};
            end
            default: ;
        endcase
        if (r_state == S_IDLE && in_acc && !r_in_msg && t_op'(i_operation) != OP_SKIP) begin
            cip_req.key_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= G_IDLE;
            r_in_msg  <= 1'b0;
            r_ctr     <= 32'd2;
            r_aad_cnt <= '0;
            r_txt_cnt <= '0;
            r_acc     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (r_state == S_PUSH && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && t_op'(i_operation) != OP_SKIP) begin
                        r_state <= r_in_msg ? S_DISP : S_KEYW;
                    end
                end
                S_KEYW: begin
                    if (cip_sts.done) begin
                        r_state <= S_HW;
                    end
                end
                S_HW: begin
                    if (cip_sts.done) begin
                        r_acc     <= '0;
                        r_aad_cnt <= '0;
                        r_txt_cnt <= '0;
                        r_ctr     <= 32'd2;
                        r_in_msg  <= 1'b1;
                        r_state   <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_op)
                        OP_AAD: begin
                            if (r_n == 5'd0) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_aad_cnt <= r_aad_cnt + 61'(r_n);
                                r_after   <= G_IDLE;
                                r_state   <= S_GW;
                            end
                        end
                        OP_TEXT: begin
                            r_state <= (r_n == 5'd0) ? S_PUSH : S_CW;
                        end
                        OP_FIN: begin
                            r_after <= G_J0;
                            r_state <= S_GW;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_CW: begin
                    if (cip_sts.done) begin
                        r_ctr     <= r_ctr + 32'd1;
                        r_txt_cnt <= r_txt_cnt + 61'(r_n);
                        r_after   <= G_PUSH;
                        r_state   <= S_GW;
                    end
                end
                S_GW: begin
                    if (g_done) begin
                        r_acc <= g_z;
                        case (r_after)
                            G_PUSH:  r_state <= S_PUSH;
                            G_J0:    r_state <= S_JW;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_JW: begin
                    if (cip_sts.done) begin
                        r_in_msg <= 1'b0;
                        r_state  <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!r_ov || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // word capture and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_op   <= t_op'(i_operation);
            r_data <= {i_data_high, i_data_low};
            r_n    <= n_clamp;
        end
        if (r_state == S_HW && cip_sts.done) begin
            r_hkey <= cip_sts.res;
        end
        if (r_state == S_DISP) begin
            r_res     <= '0;
            r_res_tag <= 1'b0;
            r_res_ok  <= 1'b0;
        end else if (r_state == S_CW && cip_sts.done) begin
            r_res <= ctext;
        end else if (r_state == S_JW && cip_sts.done) begin
            r_res     <= tag;
            r_res_tag <= 1'b1;
            r_res_ok  <= r_dec && (tag == r_data);
        end
        if (r_state == S_PUSH && (!r_ov || !i_out_stall)) begin
            r_out     <= r_res;
            r_out_tag <= r_res_tag;
            r_out_ok  <= r_res_ok;
        end
    end

    sgcm_cipher u_cipher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   ({r_key_h, r_key_l}),
        .i_req   (cip_req),
        .o_sts   (cip_sts)
    );

    sgcm_ghash u_ghash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (g_start),
        .i_x     (g_x),
        .i_h     (r_hkey),
        .o_done  (g_done),
        .o_z     (g_z)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_high  = r_out[127:64];
    assign o_out_low   = r_out[63:0];
    assign o_is_tag    = r_out_tag;
    assign o_tag_ok    = r_out_ok;
endmodule
`default_nettype wire

// ----- hw/rtl/sgcm_ghash.sv -----
`default_nettype none
module sgcm_ghash (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_x,
    input  wire logic [127:0] i_h,
    output logic              o_done,
    output logic [127:0]      o_z
);
    import sgcm_pkg::*;

    logic         r_busy;
    logic         r_done;
    logic [4:0]   r_cnt;
    logic [127:0] r_x;
    logic [127:0] r_z;
    logic [127:0] r_v;
    logic [255:0] step;

    assign step = ghash_step4(r_z, r_v, r_x[127:124]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_z <= '0;
            r_v <= i_h;
        end else if (r_busy) begin
            r_x <= {r_x[123:0], 4'b0000};
            r_z <= step[255:128];
            r_v <= step[127:0];
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;
endmodule
`default_nettype wire

// ----- hw/rtl/sgcm_cipher.sv -----
`default_nettype none
module sgcm_cipher (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [127:0]       i_key,
    input  wire sgcm_pkg::t_cip_req i_req,
    output sgcm_pkg::t_cip_sts      o_sts
);
    import sgcm_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_KEY   = 4'b0010,
        C_PRIME = 4'b0100,
        C_ROUND = 4'b1000
    } t_cstate;

    t_cstate      r_state;
    logic [4:0]   r_cnt;
    logic         r_done;
    logic [127:0] r_k;
    logic [127:0] r_x;
    logic [31:0]  r_rk;
    logic [31:0]  nk;
    logic [4:0]   rd_addr;
    logic [31:0]  rk_mem [32];

    assign nk      = key_step(r_k, r_cnt);
    assign rd_addr = (r_state == C_ROUND) ? r_cnt + 5'd1 : 5'd0;

    always_ff @(posedge i_clk) begin
        if (r_state == C_KEY) begin
            rk_mem[r_cnt] <= nk;
        end
        r_rk <= rk_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    r_cnt <= '0;
                    if (i_req.key_start) begin
                        r_state <= C_KEY;
                    end else if (i_req.blk_start) begin
                        r_state <= C_PRIME;
                    end
                end
                C_KEY: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                C_PRIME: begin
                    r_state <= C_ROUND;
                end
                C_ROUND: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_req.key_start) begin
            r_k <= i_key ^ FK;
        end else if (r_state == C_KEY) begin
            r_k <= {r_k[95:0], nk};
        end
        if (r_state == C_IDLE && i_req.blk_start) begin
            r_x <= i_req.blk;
        end else if (r_state == C_ROUND) begin
            r_x <= sm4_round(r_x, r_rk);
        end
    end

    // output words come out in reverse order
    assign o_sts.done = r_done;
    assign o_sts.res  = {r_x[31:0], r_x[63:32], r_x[95:64], r_x[127:96]};
endmodule
`default_nettype wire

// ----- hw/rtl/sgcm_checker.sv -----
`default_nettype none
`include "sm4_gcm_engine_top_defines.svh"
module sgcm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [1:0] i_operation,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_is_tag,
    input wire logic       o_tag_ok
);
    import sgcm_pkg::*;

    `SGCM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result word dropped while stalled")
    `SGCM_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_operation != OP_SKIP, o_in_stall, "engine took a word without going busy")
    `SGCM_ASSERT_NOW(a_ok_on_tag, i_clk, i_rst_n, o_out_valid && o_tag_ok, o_is_tag, "tag match flagged on a text word")
endmodule

bind sm4_gcm_engine_top sgcm_checker u_sgcm_checker (.*);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sgcm_pkg::*;

    // result word as seen on the output channel
    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        is_tag;
        logic        tag_ok;
    } t_res;

    // GCM predictor with its own copy of the engine state
    class gcm_scoreboard;
        logic [63:0]  key_h, key_l, iv_h;
        logic [31:0]  iv_l;
        logic         dec;
        logic [31:0]  rk [32];
        logic [127:0] hkey, hacc;
        logic [31:0]  ctr;
        logic [60:0]  aad_cnt, txt_cnt;
        logic         busy;
        t_res         pending [$];
        int           errors;

        function new();
            key_h = '0; key_l = '0; iv_h = '0; iv_l = '0; dec = 1'b0;
            hkey = '0; hacc = '0; ctr = 32'd2; aad_cnt = '0; txt_cnt = '0;
            busy = 1'b0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                REG_KEY_H: key_h = v;
                REG_KEY_L: key_l = v;
                REG_IV_H:  iv_h = v;
                REG_IV_L:  iv_l = v[31:0];
                REG_DEC:   dec = v[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] sb(logic [7:0] a);
            logic [7:0] t [256];
            t = '{
              8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
              8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
              8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
              8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
              8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
              8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
              8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
              8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
              8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
              8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
              8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
              8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
              8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
              8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
              8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
              8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
            return t[a];
        endfunction

        function logic [31:0] subw(logic [31:0] x);
            return {sb(x[31:24]), sb(x[23:16]), sb(x[15:8]), sb(x[7:0])};
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void expand();
            logic [31:0] k [4];
            logic [31:0] ck, b, nk;
            logic [7:0]  c;
            k[0] = key_h[63:32] ^ 32'hA3B1BAC6; k[1] = key_h[31:0] ^ 32'h56AA3350;
            k[2] = key_l[63:32] ^ 32'h677D9197; k[3] = key_l[31:0] ^ 32'hB27022DC;
            for (int i = 0; i < 32; i++) begin
                ck = '0;
                for (int j = 0; j < 4; j++) begin
                    c = 8'((4 * i + j) * 7);
                    ck[31 - 8*j -: 8] = c;
                end
                b = subw(k[1] ^ k[2] ^ k[3] ^ ck);
                nk = k[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
                rk[i] = nk;
                k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
            end
        endfunction

        function logic [127:0] encipher(logic [127:0] blk);
            logic [31:0] x [4];
            logic [31:0] b, nx;
            x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
            for (int i = 0; i < 32; i++) begin
                b = subw(x[1] ^ x[2] ^ x[3] ^ rk[i]);
                nx = x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
                x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
            end
            return {x[3], x[2], x[1], x[0]};
        endfunction

        function void absorb(logic [127:0] blk);
            logic [127:0] xv, v, z;
            logic         lsb;
            xv = hacc ^ blk; v = hkey; z = '0;
            for (int i = 127; i >= 0; i--) begin
                if (xv[i]) z ^= v;
                lsb = v[0];
                v = v >> 1;
                if (lsb) v[127:120] ^= 8'hE1;
            end
            hacc = z;
        endfunction

        function logic [127:0] byte_mask(int n);
            logic [127:0] m;
            for (int b = 0; b < 16; b++) m[127 - 8*b -: 8] = (b < n) ? 8'hFF : 8'h00;
            return m;
        endfunction

        // note an accepted input word, queue the result it causes (AAD and skip words cause none)
        function void note_input(t_op op, logic [63:0] dh, logic [63:0] dl, logic [4:0] vb);
            int           n;
            logic [127:0] m, ks, ct, tag;
            t_res         r;
            if (op == OP_SKIP) return;
            n = (vb > 16) ? 16 : vb;
            if (!busy) begin
                expand();
                hkey = encipher('0);
                ctr = 32'd2; hacc = '0; aad_cnt = '0; txt_cnt = '0; busy = 1'b1;
            end
            m = byte_mask(n);
            r.is_tag = 1'b0; r.tag_ok = 1'b0; r.hi = '0; r.lo = '0;
            case (op)
                OP_AAD: begin
                    if (n == 0) return;
                    absorb({dh, dl} & m);
                    aad_cnt += 61'(n);
                    return;
                end
                OP_TEXT: begin
                    if (n != 0) begin
                        ks = encipher({iv_h, iv_l, ctr});
                        ct = ({dh, dl} ^ ks) & m;
                        absorb(dec ? ({dh, dl} & m) : ct);
                        ctr++;
                        txt_cnt += 61'(n);
                        {r.hi, r.lo} = ct;
                    end
                end
                default: begin
                    absorb({aad_cnt, 3'b0, txt_cnt, 3'b0});
                    tag = encipher({iv_h, iv_l, 32'd1}) ^ hacc;
                    {r.hi, r.lo} = tag;
                    r.is_tag = 1'b1;
                    r.tag_ok = dec && (tag == {dh, dl});
                    busy = 1'b0;
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res w;
            if (pending.size() == 0) begin
                $error("unexpected result word hi=%h lo=%h", got.hi, got.lo);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.hi !== w.hi) begin
                $error("out_high exp %h got %h", w.hi, got.hi); errors++;
            end
            if (got.lo !== w.lo) begin
                $error("out_low exp %h got %h", w.lo, got.lo); errors++;
            end
            if (got.is_tag !== w.is_tag) begin
                $error("is_tag exp %b got %b", w.is_tag, got.is_tag); errors++;
            end
            if (got.tag_ok !== w.tag_ok) begin
                $error("tag_ok exp %b got %b", w.tag_ok, got.tag_ok); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation = '0;
    logic [63:0] i_data_high = '0;
    logic [63:0] i_data_low = '0;
    logic [4:0]  i_valid_bytes = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_out_high, o_out_low;
    logic        o_is_tag, o_tag_ok;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    gcm_scoreboard gcm = new();
    bit          quiet = 1'b0;
    bit          hold_off = 1'b0;
    longint      cycles = 0;

    sm4_gcm_engine_top uut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // monitor: compare every accepted result word
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            r.hi = o_out_high; r.lo = o_out_low; r.is_tag = o_is_tag; r.tag_ok = o_tag_ok;
            gcm.check_result(r);
        end
    end

    // receiver stall pattern: random bursts, or a long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        gcm.write_reg(idx, v);
    endtask

    // valid stays up after a take so the next word can follow at once; drop it on a gap
    task automatic send_word(t_op op, logic [63:0] dh, logic [63:0] dl, logic [4:0] vb);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op; i_data_high <= dh; i_data_low <= dl; i_valid_bytes <= vb;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gcm.note_input(op, dh, dl, vb);
    endtask

    // drain, then let the last AAD word settle before touching registers
    task automatic wait_idle();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (gcm.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    task automatic settings(bit extreme, bit dec);
        logic [63:0] kh, kl, ih, il;
        kh = extreme ? {64{dec}} : {$urandom, $urandom};
        kl = extreme ? {64{dec}} : {$urandom, $urandom};
        ih = extreme ? {64{dec}} : {$urandom, $urandom};
        il = extreme ? {64{dec}} : {32'd0, $urandom};
        write_reg(REG_KEY_H, kh);
        write_reg(REG_KEY_L, kl);
        write_reg(REG_IV_H, ih);
        write_reg(REG_IV_L, il);
        write_reg(REG_DEC, {63'd0, dec});
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // mostly well-formed messages: AAD, text, finish; a little noise
    task automatic random_item();
        int   sel;
        t_op  op;
        logic [4:0] vb;
        logic [63:0] th, tl;
        sel = $urandom_range(0, 99);
        vb = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
        if (sel < 3) op = OP_SKIP;
        else if (sel < 20) op = OP_AAD;
        else if (sel < 88) op = OP_TEXT;
        else op = OP_FIN;
        th = rnd64(); tl = rnd64();
        if (op == OP_FIN && gcm.dec && $urandom_range(0, 1)) begin
            // supply the correct tag by predicting on a copy
            gcm_scoreboard sh;
            sh = new();
            sh.key_h = gcm.key_h; sh.key_l = gcm.key_l; sh.iv_h = gcm.iv_h;
            sh.iv_l = gcm.iv_l; sh.dec = gcm.dec; sh.rk = gcm.rk; sh.hkey = gcm.hkey;
            sh.hacc = gcm.hacc; sh.ctr = gcm.ctr; sh.aad_cnt = gcm.aad_cnt;
            sh.txt_cnt = gcm.txt_cnt; sh.busy = gcm.busy;
            sh.note_input(OP_FIN, '0, '0, 5'd16);
            th = sh.pending[0].hi; tl = sh.pending[0].lo;
        end
        send_word(op, th, tl, vb);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, extremes of data and byte counts, skip code
        settings(1'b1, 1'b0);
        send_word(OP_FIN, '1, '1, 5'd16);
        send_word(OP_AAD, '1, '1, 5'd16);
        send_word(OP_AAD, '1, '0, 5'd5);
        send_word(OP_AAD, '0, '1, 5'd0);
        send_word(OP_TEXT, '0, '0, 5'd16);
        send_word(OP_TEXT, '1, '1, 5'd31);
        send_word(OP_TEXT, '1, '1, 5'd0);
        send_word(OP_TEXT, '1, '1, 5'd9);
        send_word(OP_SKIP, '1, '1, 5'd16);
        send_word(OP_AAD, rnd64(), rnd64(), 5'd8);
        send_word(OP_FIN, '0, '0, 5'd0);
        wait_idle();
        settings(1'b1, 1'b1);
        send_word(OP_AAD, rnd64(), rnd64(), 5'd16);
        send_word(OP_TEXT, '1, '0, 5'd16);
        send_word(OP_TEXT, rnd64(), rnd64(), 5'd1);
        send_word(OP_FIN, '1, '1, 5'd16);
        send_word(OP_TEXT, rnd64(), rnd64(), 5'd16);
        send_word(OP_FIN, rnd64(), rnd64(), 5'd16);
        wait_idle();

        // random phases with changing settings
        for (int ph = 0; ph < 8; ph++) begin
            settings(1'b0, ph[0]);
            if (ph == 2) hold_off = 1'b1;
            if (ph == 7) quiet = 1'b1;
            for (int i = 0; i < 125; i++) random_item();
            send_word(OP_FIN, rnd64(), rnd64(), 5'd16);
            wait_idle();
        end

        if (gcm.errors == 0 && gcm.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (gcm.pending.size() != 0) $error("%0d results never arrived", gcm.pending.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/sgcm_pkg.sv
hw/rtl/sgcm_ghash.sv
hw/rtl/sgcm_cipher.sv
hw/rtl/sm4_gcm_engine_top.sv
hw/rtl/sgcm_checker.sv
tb/sv/testbench.sv
